// ===== src/mpt_pkg.sv =====
// Shared constants, handshake structs and index helpers for the power tower evaluator.
package mpt_pkg;

  localparam int CHAIN_DEPTH = 64;
  localparam int CHAIN_AW    = $clog2(CHAIN_DEPTH);
  localparam int VAL_W       = 30;
  localparam int OUT_W       = 31;
  localparam int IDX_W       = 6;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic             b_big;
    logic [VAL_W-1:0] m;
  } mpt_mm_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] prod;
    logic             big;
  } mpt_mm_rsp_t;

  function automatic logic [CHAIN_AW-1:0] idx_of(logic [IDX_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[CHAIN_AW-1:0];
  endfunction

  function automatic logic idx_in_table(logic [IDX_W-1:0] v);
    return 32'(v) < 32'(CHAIN_DEPTH);
  endfunction

  function automatic logic [CHAIN_AW-1:0] sat_depth(logic [IDX_W-1:0] d);
    logic [31:0] w;
    w = 32'(d);
    if (w >= 32'(CHAIN_DEPTH)) begin
      w = 32'(CHAIN_DEPTH - 1);
    end
    return w[CHAIN_AW-1:0];
  endfunction

endpackage

// ===== src/mpt_modmul.sv =====
// Bit-serial modular multiplier with a flag for a true product at or above the modulus.
module mpt_modmul
  import mpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mpt_mm_req_t req,
  output mpt_mm_rsp_t rsp
);

  localparam int CNT_W = $clog2(VAL_W);
  localparam int T_W   = VAL_W + 2;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(VAL_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] a_sh;
  logic [VAL_W-1:0] b;
  logic             b_big;
  logic [VAL_W-1:0] m;
  logic [VAL_W-1:0] r;
  logic             big;

  logic             bit_in;
  logic [T_W-1:0]   t;
  logic [T_W-1:0]   m1;
  logic [T_W-1:0]   m2;
  logic [VAL_W-1:0] r_next;
  logic             big_next;

  // r tracks the partial product mod m; t stays below 3m since r and b are reduced
  always_comb begin
    bit_in = a_sh[VAL_W-1];
    m1     = {2'b00, m};
    m2     = {1'b0, m, 1'b0};
    t      = {1'b0, r, 1'b0} + (bit_in ? {2'b00, b} : '0);
    if (t >= m2) begin
      r_next = VAL_W'(t - m2);
    end else if (t >= m1) begin
      r_next = VAL_W'(t - m1);
    end else begin
      r_next = VAL_W'(t);
    end
    // exact partial product equals r until the flag is first raised
    big_next = big | (bit_in & b_big) | (t >= m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sh  <= req.a;
      b     <= req.b;
      b_big <= req.b_big;
      m     <= req.m;
      r     <= '0;
      big   <= 1'b0;
    end else if (busy) begin
      a_sh <= {a_sh[VAL_W-2:0], 1'b0};
      r    <= r_next;
      big  <= big_next;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = r;
  assign rsp.big  = big;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("multiplier restarted while busy");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (r < m))
    else $error("multiplier result not reduced");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == LAST && !req.start) |=> done)
    else $error("multiplier missed its done pulse");

endmodule

// ===== src/modular_power_tower_eval.sv =====
// Power tower evaluator: modulus chain memory, level sequencer and two bit-serial multipliers.
//
//   channel  direction  signals                                              handshake
//   in       input      req_type chain_index modulus_value leaf_value         in_valid/in_ready
//                       tower_depth
//   out      output     tower_value                                          out_valid/out_ready
//   cfg      input      tower_base                                           cfg_valid/cfg_ready
//
// A load word is written to the chain memory. An evaluate word first reduces the leaf,
// then per level reduces the base, runs a square, and a multiply where the bit is set, for
// each exponent bit (up to 31 bits), closes the level, and hands the result to the output
// register. The run time is set by the modular multipliers, which consume one multiplier bit
// per cycle; multiply and square of one exponent bit run side by side.
// Reset sets the stored base (base_cfg) to 2; the chain memory is not cleared.
// A finished result waits in the output register; a new word is taken meanwhile.
module modular_power_tower_eval
  import mpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [IDX_W-1:0] chain_index,
  input  logic [VAL_W-1:0] modulus_value,
  input  logic [VAL_W-1:0] leaf_value,
  input  logic [IDX_W-1:0] tower_depth,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] tower_value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] tower_base
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_LEAF_M   = 8'b0000_0010,
    ST_LEAF_RED = 8'b0000_0100,
    ST_LVL_M    = 8'b0000_1000,
    ST_BASE_RED = 8'b0001_0000,
    ST_POW_STEP = 8'b0010_0000,
    ST_POW_WAIT = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [CHAIN_AW-1:0] level;
  logic [VAL_W-1:0]    leaf;
  logic [VAL_W-1:0]    m;
  logic [OUT_W-1:0]    r_val;
  logic [OUT_W-1:0]    e;
  logic [VAL_W-1:0]    acc;
  logic                reached;
  logic                sq_big;
  logic [VAL_W-1:0]    base_v;
  logic [VAL_W-1:0]    base_red;
  logic                base_big;
  logic [VAL_W-1:0]    base_cfg;
  logic [OUT_W-1:0]    out_q;

  logic [VAL_W-1:0]    mem [CHAIN_DEPTH];
  logic [VAL_W-1:0]    mem_q;
  logic [CHAIN_AW-1:0] rd_addr;

  logic                in_acc;
  logic                out_free;
  logic [VAL_W-1:0]    m_eff;
  logic [VAL_W-1:0]    one_red;
  logic                one_big;
  logic [OUT_W-1:0]    leaf_sum;
  logic [OUT_W-1:0]    lvl_sum;

  mpt_mm_req_t req_a;
  mpt_mm_req_t req_b;
  mpt_mm_rsp_t rsp_a;
  mpt_mm_rsp_t rsp_b;

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_cfg <= VAL_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      base_cfg <= tower_base;
    end
  end

  // chain memory: one write port, one registered read port
  assign rd_addr = (state == ST_IDLE) ? sat_depth(tower_depth) : level - 1'b1;

  always_ff @(posedge clk) begin
    if (in_acc && req_type == REQ_LOAD && idx_in_table(chain_index)) begin
      mem[idx_of(chain_index)] <= modulus_value;
    end
    mem_q <= mem[rd_addr];
  end

  // a zero entry acts as a modulus of one; 1 mod m is zero only then
  always_comb begin
    m_eff    = (mem_q == '0) ? VAL_W'(1) : mem_q;
    one_big  = (m_eff == VAL_W'(1));
    one_red  = one_big ? '0 : VAL_W'(1);
    leaf_sum = {1'b0, rsp_a.prod} + (rsp_a.big ? {1'b0, m} : '0);
    lvl_sum  = {1'b0, acc} + (reached ? {1'b0, m} : '0);
  end

  always_comb begin
    req_a = '0;
    req_b = '0;
    case (state)
      ST_LEAF_M: begin
        req_a = '{start: 1'b1, a: leaf, b: one_red, b_big: one_big, m: m_eff};
      end
      ST_LVL_M: begin
        req_a = '{start: 1'b1, a: base_cfg, b: one_red, b_big: one_big, m: m_eff};
      end
      ST_POW_STEP: begin
        if (e != '0) begin
          req_a = '{start: e[0], a: acc, b: base_red, b_big: base_big, m: m};
          req_b = '{start: 1'b1, a: base_v, b: base_red, b_big: base_big, m: m};
        end
      end
      default: begin
        req_a = '0;
        req_b = '0;
      end
    endcase
  end

  mpt_modmul u_mul_acc (
    .clk (clk),
    .rst (rst),
    .req (req_a),
    .rsp (rsp_a)
  );

  mpt_modmul u_mul_sq (
    .clk (clk),
    .rst (rst),
    .req (req_b),
    .rsp (rsp_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && req_type == REQ_EVAL) begin
            state <= ST_LEAF_M;
          end
        end
        ST_LEAF_M: begin
          state <= ST_LEAF_RED;
        end
        ST_LEAF_RED: begin
          if (rsp_a.done) begin
            state <= (level == '0) ? ST_DONE : ST_LVL_M;
          end
        end
        ST_LVL_M: begin
          state <= ST_BASE_RED;
        end
        ST_BASE_RED: begin
          if (rsp_a.done) begin
            state <= ST_POW_STEP;
          end
        end
        ST_POW_STEP: begin
          if (e == '0) begin
            state <= (level == '0) ? ST_DONE : ST_LVL_M;
          end else begin
            state <= ST_POW_WAIT;
          end
        end
        ST_POW_WAIT: begin
          if (rsp_b.done) begin
            state <= ST_POW_STEP;
          end
        end
        ST_DONE: begin
          // hold the result until the output register frees up
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          leaf  <= leaf_value;
          level <= sat_depth(tower_depth);
        end
      end
      ST_LEAF_M: begin
        m <= m_eff;
      end
      ST_LEAF_RED: begin
        if (rsp_a.done) begin
          r_val <= leaf_sum;
          if (level != '0) begin
            level <= level - 1'b1;
          end
        end
      end
      ST_LVL_M: begin
        m       <= m_eff;
        e       <= r_val;
        acc     <= VAL_W'(1);
        reached <= 1'b0;
        sq_big  <= 1'b0;
      end
      ST_BASE_RED: begin
        if (rsp_a.done) begin
          base_v   <= base_cfg;
          base_red <= rsp_a.prod;
          base_big <= rsp_a.big;
        end
      end
      ST_POW_STEP: begin
        if (e == '0) begin
          r_val <= lvl_sum;
          if (level != '0) begin
            level <= level - 1'b1;
          end
        end
      end
      ST_POW_WAIT: begin
        if (rsp_b.done) begin
          if (e[0]) begin
            acc     <= rsp_a.prod;
            reached <= reached | rsp_a.big | sq_big;
          end
          sq_big   <= sq_big | rsp_b.big;
          base_v   <= rsp_b.prod;
          base_red <= rsp_b.prod;
          base_big <= 1'b0;
          e        <= e >> 1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q <= r_val;
        end
      end
      default: begin
        level <= level;
      end
    endcase
  end

  assign tower_value = out_q;

  a_mul_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POW_WAIT && rsp_b.done) |-> (rsp_a.done == e[0]))
    else $error("multiply and square finished out of step");

  a_exp_shift: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POW_WAIT && rsp_b.done) |=> (e == ($past(e) >> 1)))
    else $error("exponent did not advance by one bit");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the finish state");

  a_acc_done_wait: assert property (@(posedge clk) disable iff (rst)
    rsp_a.done |-> (state == ST_LEAF_RED || state == ST_BASE_RED || state == ST_POW_WAIT))
    else $error("multiplier finished while nobody waits");

endmodule
